@@ rtl/assert_macros.svh @@
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define SPBE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define SPBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SPBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/spbe_pkg.sv @@
// Types, constants and code table function of the prefix byte encoder.
`timescale 1ns / 1ps
`default_nettype none

package spbe_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SEGB_W    = 13;
    localparam int unsigned CODE_W    = 11;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = 2;
    localparam int unsigned Q_CNT_W   = 3;

    typedef struct packed {
        logic [WORD_W-1:0] code_word;
        logic              last_word;
        logic [SEGB_W-1:0] segment_bytes;
    } t_result;

    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } t_code;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result e0;
        t_result e1;
    } t_push_req;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_q_head;

    function automatic t_code code_of(input logic [7:0] v);
        t_code      c;
        logic [7:0] t;
        t = 8'd0;
        priority if (v <= 8'd3) begin
            c.bits = CODE_W'({v[1:0], 1'b0});
            c.len  = LEN_W'(3);
        end else if (v <= 8'd19) begin
            t      = v - 8'd4;
            c.bits = CODE_W'({t[3:0], 2'b01});
            c.len  = LEN_W'(6);
        end else if (v <= 8'd83) begin
            t      = v - 8'd20;
            c.bits = CODE_W'({t[5:0], 3'b011});
            c.len  = LEN_W'(9);
        end else begin
            t      = v - 8'd84;
            c.bits = {t, 3'b111};
            c.len  = LEN_W'(11);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/spbe_if.sv @@
// Stream interfaces for the byte input and the code word output.
`timescale 1ns / 1ps
`default_nettype none

interface spbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_block;

    modport source (output valid, output data_byte, output end_of_block, input ready);
    modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

interface spbe_out_if;
    logic                             valid;
    logic                             ready;
    logic [spbe_pkg::WORD_W-1:0]      code_word;
    logic                             last_word;
    logic [spbe_pkg::SEGB_W-1:0]      segment_bytes;

    modport source (output valid, output code_word, output last_word,
                    output segment_bytes, input ready);
    modport sink   (input valid, input code_word, input last_word,
                    input segment_bytes, output ready);
endinterface

`default_nettype wire

@@ rtl/spbe_front.sv @@
// Front end: accept bytes, look up codes, pack bits and close segments.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spbe_front #(
    parameter int unsigned SEGMENT_BYTES = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_end_of_block,
    input  wire logic                  i_space_ok,
    output spbe_pkg::t_push_req        o_push
);

    localparam int unsigned IDX_W = $clog2(SEGMENT_BYTES + 1);
    localparam int unsigned TOT_W = $clog2(SEGMENT_BYTES * 11 + 1);
    localparam int unsigned ACC_W = spbe_pkg::WORD_W + spbe_pkg::CODE_W;

    logic [spbe_pkg::WORD_W-1:0] r_bits, n_bits;
    logic [4:0]                  r_cnt, n_cnt;
    logic [TOT_W-1:0]            r_total, n_total;
    logic [IDX_W-1:0]            r_idx, n_idx;

    spbe_pkg::t_code             code;
    logic [ACC_W-1:0]            acc;
    logic [5:0]                  newcnt;
    logic                        full;
    logic [4:0]                  rest;
    logic                        accept;
    logic                        closing;
    logic [TOT_W-1:0]            sum_total;
    logic [IDX_W-1:0]            sum_idx;
    logic [TOT_W:0]              rnd;
    logic [spbe_pkg::SEGB_W-1:0] seg;

    assign o_ready = i_space_ok;
    assign accept  = i_valid && o_ready;

    always_comb begin
        code      = spbe_pkg::code_of(i_data_byte);
        acc       = {{spbe_pkg::CODE_W{1'b0}}, r_bits} | (ACC_W'(code.bits) << r_cnt);
        newcnt    = {1'b0, r_cnt} + 6'(code.len);
        full      = newcnt[5];
        rest      = newcnt[4:0];
        sum_total = r_total + TOT_W'(code.len);
        sum_idx   = r_idx + IDX_W'(1);
        closing   = i_end_of_block || (sum_idx >= IDX_W'(SEGMENT_BYTES));
        rnd       = {1'b0, sum_total} + (TOT_W + 1)'(31);
        seg       = spbe_pkg::SEGB_W'(rnd >> 5) << 2;
    end

    always_comb begin
        o_push.push0            = accept && (full || closing);
        o_push.push1            = accept && full && closing && (rest != 5'd0);
        o_push.e0.code_word     = acc[spbe_pkg::WORD_W-1:0];
        o_push.e0.last_word     = closing && (!full || rest == 5'd0);
        o_push.e0.segment_bytes = o_push.e0.last_word ? seg : '0;
        o_push.e1.code_word     = spbe_pkg::WORD_W'(acc[ACC_W-1:spbe_pkg::WORD_W]);
        o_push.e1.last_word     = 1'b1;
        o_push.e1.segment_bytes = seg;
    end

    always_comb begin
        n_bits  = r_bits;
        n_cnt   = r_cnt;
        n_total = r_total;
        n_idx   = r_idx;
        if (accept) begin
            if (closing) begin
                n_bits  = '0;
                n_cnt   = '0;
                n_total = '0;
                n_idx   = '0;
            end else begin
                n_bits  = full ? spbe_pkg::WORD_W'(acc[ACC_W-1:spbe_pkg::WORD_W])
                               : acc[spbe_pkg::WORD_W-1:0];
                n_cnt   = rest;
                n_total = sum_total;
                n_idx   = sum_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_cnt   <= '0;
            r_total <= '0;
            r_idx   <= '0;
        end else begin
            r_bits  <= n_bits;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_idx   <= n_idx;
        end
    end

    `SPBE_ASSERT_NXT(a_close_clears, i_clk, i_rst_n, accept && closing,
        r_cnt == 5'd0 && r_idx == '0, "segment state not cleared after close")

endmodule

`default_nettype wire

@@ rtl/spbe_queue.sv @@
// Four-entry result queue, up to two writes and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spbe_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire spbe_pkg::t_push_req  i_push,
    output logic                      o_space_ok,
    output spbe_pkg::t_q_head         o_head,
    input  wire logic                 i_pop
);

    spbe_pkg::t_result              r_mem [spbe_pkg::Q_DEPTH];
    logic [spbe_pkg::Q_PTR_W-1:0]   r_wr, r_rd;
    logic [spbe_pkg::Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic [spbe_pkg::Q_PTR_W-1:0]   wr_nxt;
    logic                           pop;

    assign pop        = i_pop && (r_cnt != '0);
    assign wr_nxt     = r_wr + spbe_pkg::Q_PTR_W'(1);
    assign o_space_ok = r_cnt <= spbe_pkg::Q_CNT_W'(spbe_pkg::Q_DEPTH - 2);
    assign o_head.valid = r_cnt != '0;
    assign o_head.data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt + spbe_pkg::Q_CNT_W'(i_push.push0) + spbe_pkg::Q_CNT_W'(i_push.push1)
              - spbe_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.push1) begin
            r_mem[wr_nxt] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + spbe_pkg::Q_PTR_W'(i_push.push0) + spbe_pkg::Q_PTR_W'(i_push.push1);
            r_rd  <= r_rd + spbe_pkg::Q_PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

    `SPBE_ASSERT(a_cnt_bound, i_clk, i_rst_n,
        r_cnt <= spbe_pkg::Q_CNT_W'(spbe_pkg::Q_DEPTH), "queue count over depth")
    `SPBE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.push0, o_space_ok,
        "queue written without room for two entries")
    `SPBE_ASSERT_IMP(a_push_order, i_clk, i_rst_n, i_push.push1, i_push.push0,
        "second entry written without the first")

endmodule

`default_nettype wire

@@ rtl/spbe_back.sv @@
// Back end: output register that drains the result queue.
`timescale 1ns / 1ps
`default_nettype none

module spbe_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spbe_pkg::t_q_head  i_head,
    output logic                    o_pop,
    spbe_out_if.source              o_out
);

    logic              r_valid;
    spbe_pkg::t_result r_data;
    logic              load;

    assign load  = i_head.valid && (!r_valid || o_out.ready);
    assign o_pop = load;

    assign o_out.valid         = r_valid;
    assign o_out.code_word     = r_data.code_word;
    assign o_out.last_word     = r_data.last_word;
    assign o_out.segment_bytes = r_data.segment_bytes;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_head.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/static_prefix_byte_encoder.sv @@
// Top level of the static prefix byte encoder.
//
//  channel  dir  transfer when       payload
//  i_in     in   valid && ready      data_byte[7:0], end_of_block
//  o_out    out  valid && ready      code_word[31:0], last_word, segment_bytes[12:0]
//
// One byte is taken per cycle while the queue has room; the packer state is a register updated on each accepted byte.
// Each byte yields zero, one or two words into a four-entry queue; input stalls
// only while fewer than two queue entries are free.
// A queued word passes from the queue memory through the output register to o_out.
// Synchronous active-low reset empties the queue and clears the segment state.
`timescale 1ns / 1ps
`default_nettype none

module static_prefix_byte_encoder #(
    parameter int unsigned SEGMENT_BYTES = 4096
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    spbe_in_if.sink      i_in,
    spbe_out_if.source   o_out
);

    spbe_pkg::t_push_req push;
    spbe_pkg::t_q_head   head;
    logic                space_ok;
    logic                pop;

    spbe_front #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_data_byte    (i_in.data_byte),
        .i_end_of_block (i_in.end_of_block),
        .i_space_ok     (space_ok),
        .o_push         (push)
    );

    spbe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_head     (head),
        .i_pop      (pop)
    );

    spbe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ dv/spbe_checker.sv @@
// Monitor, encoder prediction and word comparison for the prefix byte encoder bench.
`timescale 1ns / 1ps

module spbe_checker #(
    parameter int unsigned SEG_BYTES = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spbe_in_if   i_bytes,
    spbe_out_if  i_words,
    output int   o_fail_count,
    output int   o_pending
);

    spbe_pkg::t_result expected_words[$];

    logic [31:0] held_bits;
    logic [5:0]  held_count;
    logic [15:0] seg_bit_sum;
    logic [12:0] seg_byte_count;
    int          fail_total;

    task automatic encode_byte(input logic [7:0] b, input logic eob);
        logic [10:0]       code;
        logic [7:0]        offset;
        int unsigned       width;
        int unsigned       fill;
        int unsigned       rest;
        logic [63:0]       acc;
        logic              closing;
        logic [12:0]       seg_len;
        spbe_pkg::t_result word;
        offset = 8'd0;
        if (b <= 8'd3) begin
            code  = {8'd0, b[1:0], 1'b0};
            width = 3;
        end else if (b <= 8'd19) begin
            offset = b - 8'd4;
            code   = {5'd0, offset[3:0], 2'b01};
            width  = 6;
        end else if (b <= 8'd83) begin
            offset = b - 8'd20;
            code   = {2'd0, offset[5:0], 3'b011};
            width  = 9;
        end else begin
            offset = b - 8'd84;
            code   = {offset, 3'b111};
            width  = 11;
        end
        acc            = {32'd0, held_bits} | (64'(code) << held_count);
        fill           = held_count + width;
        seg_bit_sum    = seg_bit_sum + 16'(width);
        seg_byte_count = seg_byte_count + 13'd1;
        closing        = eob || (seg_byte_count >= 13'(SEG_BYTES));
        seg_len        = 13'd0;
        if (closing) begin
            seg_len = 13'((((32'(seg_bit_sum) + 32'd7) / 32'd8) + 32'd3) & ~32'd3);
        end
        if (fill >= 32) begin
            rest               = fill - 32;
            word.code_word     = acc[31:0];
            word.last_word     = closing && (rest == 0);
            word.segment_bytes = word.last_word ? seg_len : 13'd0;
            expected_words     = {expected_words, word};
            acc  = acc >> 32;
            fill = rest;
        end
        if (closing) begin
            if (fill > 0) begin
                word.code_word     = acc[31:0];
                word.last_word     = 1'b1;
                word.segment_bytes = seg_len;
                expected_words     = {expected_words, word};
            end
            held_bits      = 32'd0;
            held_count     = 6'd0;
            seg_bit_sum    = 16'd0;
            seg_byte_count = 13'd0;
        end else begin
            held_bits  = acc[31:0];
            held_count = 6'(fill);
        end
    endtask

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        spbe_pkg::t_result want;
        if (!i_rst_n) begin
            held_bits      = 32'd0;
            held_count     = 6'd0;
            seg_bit_sum    = 16'd0;
            seg_byte_count = 13'd0;
            expected_words.delete();
        end else begin
            if (i_words.valid && i_words.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: code_word %h last_word %b segment_bytes %0d",
                           i_words.code_word, i_words.last_word, i_words.segment_bytes);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_words.code_word !== want.code_word) begin
                        $error("code_word: expected %h, actual %h",
                               want.code_word, i_words.code_word);
                        fail_total++;
                    end
                    if (i_words.last_word !== want.last_word) begin
                        $error("last_word: expected %b, actual %b",
                               want.last_word, i_words.last_word);
                        fail_total++;
                    end
                    if (i_words.segment_bytes !== want.segment_bytes) begin
                        $error("segment_bytes: expected %0d, actual %0d",
                               want.segment_bytes, i_words.segment_bytes);
                        fail_total++;
                    end
                end
            end
            if (i_bytes.valid && i_bytes.ready) begin
                encode_byte(i_bytes.data_byte, i_bytes.end_of_block);
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ dv/tb_top.sv @@
// Top of the prefix byte encoder bench: clock, reset, byte stimulus, word sink and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned SEG_LEN      = 4096;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          LONG_HOLD    = 400;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_SPARSE,
        STALL_PERIODIC
    } t_stall_mode;

    // {end_of_block, data_byte}
    localparam logic [8:0] DIRECTED [20] = '{
        {1'b1, 8'd0},   {1'b1, 8'd255}, {1'b1, 8'd3},   {1'b1, 8'd4},
        {1'b1, 8'd19},  {1'b1, 8'd20},  {1'b1, 8'd83},  {1'b1, 8'd84},
        {1'b0, 8'd255}, {1'b0, 8'd83},  {1'b0, 8'd19},  {1'b0, 8'd3},
        {1'b1, 8'd0},
        {1'b0, 8'd200}, {1'b0, 8'd200}, {1'b1, 8'd255},
        {1'b0, 8'd84},  {1'b0, 8'd84},  {1'b0, 8'd84},  {1'b1, 8'd1}
    };

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   burst_left = 0;
    int   steady_left = 0;

    spbe_in_if  in_ch ();
    spbe_out_if out_ch ();

    static_prefix_byte_encoder #(
        .SEGMENT_BYTES(SEG_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    spbe_checker #(
        .SEG_BYTES(SEG_LEN)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bytes     (in_ch),
        .i_words     (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(0, 3));
            1:       return 8'($urandom_range(4, 19));
            2:       return 8'($urandom_range(20, 83));
            3:       return 8'($urandom_range(84, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (steady_left > 0) ? 0 : $urandom_range(1, 8);
            if (steady_left > 0) begin
                steady_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                steady_left = $urandom_range(5, 20);
            end
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.end_of_block <= eob;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          words_seen;
        int          phase;
        bit          hold_done;
        mode       = STALL_NONE;
        mode_left  = 0;
        hold_left  = 0;
        words_seen = 0;
        phase      = 0;
        hold_done  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                if (out_ch.valid && out_ch.ready) begin
                    words_seen++;
                end
                phase++;
                if (hold_left > 0) begin
                    hold_left--;
                    out_ch.ready <= 1'b0;
                end else if (!hold_done && words_seen >= 40) begin
                    // hold off long enough for the input side to back up
                    hold_done = 1'b1;
                    hold_left = LONG_HOLD;
                    out_ch.ready <= 1'b0;
                end else begin
                    if (mode_left == 0) begin
                        mode      = t_stall_mode'($urandom_range(0, 3));
                        mode_left = $urandom_range(20, 200);
                    end else begin
                        mode_left--;
                    end
                    case (mode)
                        STALL_NONE:     out_ch.ready <= 1'b1;
                        STALL_HALF:     out_ch.ready <= 1'($urandom_range(0, 1));
                        STALL_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                        STALL_PERIODIC: out_ch.ready <= ((phase % 5) == 0);
                        default:        out_ch.ready <= 1'b1;
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        int k;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= 8'd0;
        in_ch.end_of_block <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[n]) begin
            send_byte(DIRECTED[n][7:0], DIRECTED[n][8]);
        end

        for (k = 0; k < RANDOM_ITEMS / 2; k++) begin
            send_byte(pick_byte(), $urandom_range(0, 15) == 0);
        end

        // close the open segment
        send_byte(pick_byte(), 1'b1);

        for (k = 0; k < RANDOM_ITEMS / 2; k++) begin
            send_byte(pick_byte(), $urandom_range(0, 15) == 0);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
